[sv/gtf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gtf_pkg;

  localparam int unsigned TEAMS_DEF      = 1024;
  localparam int unsigned CAPACITY_DEF   = 1024;
  localparam int unsigned VALUE_BITS_DEF = 20;
  localparam int unsigned TEAM_ID_W      = 10;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned STATUS_W       = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_CLR,
    OP_RSV
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ,
    ST_DEQ,
    ST_CLR,
    ST_EMPTY,
    ST_FULL
  } status_e;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_ENQ_MOD,
    S_ENQ_WR,
    S_DEQ_TEAM,
    S_DEQ_CELL,
    S_DEQ_WR,
    S_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    latch;
    logic    clear;
    logic    sweep;
    logic    enq_mod;
    logic    enq_wr;
    logic    deq_team;
    logic    deq_cell;
    logic    deq_wr;
    logic    set_res;
    status_e res;
    logic    load_out;
  } gtf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic team_big;
    logic sweep_done;
    logic out_busy;
  } gtf_sts_t;

endpackage
`default_nettype wire

[sv/gtf_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface gtf_in_if
  import gtf_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [VALUE_BITS-1:0] item_value;
  logic [TEAM_ID_W-1:0]  team_id;

  modport source (output valid, output op, output item_value, output team_id, input ready);
  modport sink (input valid, input op, input item_value, input team_id, output ready);
endinterface
`default_nettype wire

[sv/gtf_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface gtf_out_if
  import gtf_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] out_value;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, output out_value, output status, input ready);
  modport sink (input valid, input out_value, input status, output ready);
endinterface
`default_nettype wire

[sv/gtf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module gtf_ctrl
  import gtf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic [OP_W-1:0] in_op_i,
  output logic           in_ready_o,
  input  wire gtf_sts_t  sts_i,
  output gtf_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   clr_q, clr_d;
  logic   acc;
  op_e    op;

  assign op  = op_e'(in_op_i);
  assign acc = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      clr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_SWEEP: begin
        if (sts_i.sweep_done) begin
          state_d = clr_q ? S_DONE : S_IDLE;
          clr_d   = 1'b0;
        end
      end
      S_IDLE: begin
        if (acc) begin
          unique case (op)
            OP_ENQ: state_d = sts_i.full ? S_DONE : S_ENQ_MOD;
            OP_DEQ: state_d = sts_i.empty ? S_DONE : S_DEQ_TEAM;
            OP_CLR, OP_RSV: begin
              state_d = S_SWEEP;
              clr_d   = 1'b1;
            end
          endcase
        end
      end
      S_ENQ_MOD:  if (!sts_i.team_big) state_d = S_ENQ_WR;
      S_ENQ_WR:   state_d = S_DONE;
      S_DEQ_TEAM: state_d = S_DEQ_CELL;
      S_DEQ_CELL: state_d = S_DEQ_WR;
      S_DEQ_WR:   state_d = S_DONE;
      S_DONE:     if (!sts_i.out_busy) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.res = ST_ENQ;
    unique case (state_q)
      S_SWEEP: cmd_o.sweep = 1'b1;
      S_IDLE: begin
        if (acc) begin
          cmd_o.latch = 1'b1;
          unique case (op)
            OP_ENQ: begin
              cmd_o.set_res = 1'b1;
              cmd_o.res     = sts_i.full ? ST_FULL : ST_ENQ;
            end
            OP_DEQ: begin
              cmd_o.set_res = 1'b1;
              cmd_o.res     = ST_EMPTY;
            end
            OP_CLR, OP_RSV: begin
              cmd_o.clear   = 1'b1;
              cmd_o.set_res = 1'b1;
              cmd_o.res     = ST_CLR;
            end
          endcase
        end
      end
      S_ENQ_MOD:  cmd_o.enq_mod = 1'b1;
      S_ENQ_WR:   cmd_o.enq_wr = 1'b1;
      S_DEQ_TEAM: cmd_o.deq_team = 1'b1;
      S_DEQ_CELL: cmd_o.deq_cell = 1'b1;
      S_DEQ_WR: begin
        cmd_o.deq_wr  = 1'b1;
        cmd_o.set_res = 1'b1;
        cmd_o.res     = ST_DEQ;
      end
      S_DONE:  cmd_o.load_out = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

[sv/gtf_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module gtf_dp
  import gtf_pkg::*;
#(
  parameter int unsigned TEAMS      = TEAMS_DEF,
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire gtf_cmd_t              cmd_i,
  output gtf_sts_t                   sts_o,
  input  wire logic [VALUE_BITS-1:0] item_value_i,
  input  wire logic [TEAM_ID_W-1:0]  team_id_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [VALUE_BITS-1:0]      out_value_o,
  output logic [STATUS_W-1:0]        status_o
);

  localparam int unsigned TW  = $clog2(TEAMS);
  localparam int unsigned CW  = $clog2(CAPACITY);
  localparam int unsigned TBW = (TW + 1 > TEAM_ID_W) ? TW + 1 : TEAM_ID_W;

  // memories
  logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
  logic [CW-1:0]         link_mem [CAPACITY];
  logic [CW-1:0]         head_mem [TEAMS];
  logic [CW-1:0]         tail_mem [TEAMS];
  logic                  act_mem  [TEAMS];
  logic [TW-1:0]         ord_mem  [TEAMS];

  logic [VALUE_BITS-1:0] val_rd;
  logic [CW-1:0]         link_rd, head_rd, tail_rd;
  logic                  act_rd;
  logic [TW-1:0]         ord_rd;

  // control and pointer registers
  logic [TBW-1:0]        team_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CW:0]           used_q, fresh_q;
  logic [CW-1:0]         fhead_q, cell_q;
  logic [TW-1:0]         rd_q, wr_q, sw_q;
  logic [TW:0]           ocnt_q;
  logic                  last_q;
  logic [VALUE_BITS-1:0] res_val_q, out_val_q;
  status_e               res_st_q, out_st_q;
  logic                  out_valid_q;

  logic [TW-1:0] team_idx, team_raddr;
  logic [CW-1:0] link_raddr, new_cell;
  logic          from_fresh;

  // write port selects
  logic          link_we, head_we, tail_we, act_we, val_we, ord_we;
  logic [CW-1:0] link_wa, link_wd, head_wd;
  logic [TW-1:0] act_wa;
  logic          act_wd;

  function automatic logic [TW-1:0] next_slot(input logic [TW-1:0] p);
    next_slot = (p == TW'(TEAMS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign team_idx   = team_q[TW-1:0];
  assign team_raddr = cmd_i.deq_team ? ord_rd : team_idx;
  assign link_raddr = cmd_i.deq_cell ? head_rd : fhead_q;
  assign from_fresh = (fresh_q == used_q);
  assign new_cell   = from_fresh ? fresh_q[CW-1:0] : fhead_q;

  // status to controller
  assign sts_o.full       = (used_q == (CW+1)'(CAPACITY));
  assign sts_o.empty      = (ocnt_q == '0);
  assign sts_o.team_big   = (team_q >= TBW'(TEAMS));
  assign sts_o.sweep_done = (sw_q == TW'(TEAMS - 1));
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  // write port muxing
  always_comb begin
    val_we  = cmd_i.enq_wr;
    ord_we  = cmd_i.enq_wr && !act_rd;
    tail_we = cmd_i.enq_wr;
    link_we = (cmd_i.enq_wr && act_rd) || cmd_i.deq_wr;
    link_wa = cmd_i.enq_wr ? tail_rd : cell_q;
    link_wd = cmd_i.enq_wr ? new_cell : fhead_q;
    head_we = (cmd_i.enq_wr && !act_rd) || (cmd_i.deq_wr && !last_q);
    head_wd = cmd_i.enq_wr ? new_cell : link_rd;
    act_we  = cmd_i.sweep || (cmd_i.enq_wr && !act_rd) || (cmd_i.deq_wr && last_q);
    act_wa  = cmd_i.sweep ? sw_q : team_idx;
    act_wd  = cmd_i.enq_wr;
  end

  // cell pool memories
  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[new_cell] <= val_q;
    if (link_we) link_mem[link_wa] <= link_wd;
    val_rd  <= val_mem[head_rd];
    link_rd <= link_mem[link_raddr];
  end

  // per-team memories
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[team_idx] <= head_wd;
    if (tail_we) tail_mem[team_idx] <= new_cell;
    if (act_we) act_mem[act_wa] <= act_wd;
    head_rd <= head_mem[team_raddr];
    tail_rd <= tail_mem[team_raddr];
    act_rd  <= act_mem[team_raddr];
  end

  // team order fifo memory
  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[wr_q] <= team_idx;
    ord_rd <= ord_mem[rd_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      team_q <= TBW'(team_id_i);
      val_q  <= item_value_i;
    end else if (cmd_i.enq_mod && sts_o.team_big) begin
      team_q <= team_q - TBW'(TEAMS);
    end else if (cmd_i.deq_team) begin
      team_q <= TBW'(ord_rd);
    end
    if (cmd_i.deq_cell) begin
      cell_q <= head_rd;
      last_q <= (head_rd == tail_rd);
    end
    if (cmd_i.set_res) begin
      res_st_q  <= cmd_i.res;
      res_val_q <= cmd_i.deq_wr ? val_rd : '0;
    end
    if (cmd_i.load_out) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
    end
  end

  // pool and order bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      fresh_q <= '0;
      fhead_q <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      ocnt_q  <= '0;
      sw_q    <= '0;
    end else if (cmd_i.clear) begin
      used_q  <= '0;
      fresh_q <= '0;
      fhead_q <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      ocnt_q  <= '0;
      sw_q    <= '0;
    end else begin
      if (cmd_i.sweep && !sts_o.sweep_done) sw_q <= sw_q + 1'b1;
      if (cmd_i.enq_wr) begin
        used_q <= used_q + 1'b1;
        if (from_fresh) fresh_q <= fresh_q + 1'b1;
        else fhead_q <= link_rd;
        if (!act_rd) begin
          wr_q   <= next_slot(wr_q);
          ocnt_q <= ocnt_q + 1'b1;
        end
      end
      if (cmd_i.deq_wr) begin
        used_q  <= used_q - 1'b1;
        fhead_q <= cell_q;
        if (last_q) begin
          rd_q   <= next_slot(rd_q);
          ocnt_q <= ocnt_q - 1'b1;
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_val_q;
  assign status_o    = out_st_q;

endmodule
`default_nettype wire

[sv/grouped_team_fifo_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// enqueue: accept, S_ENQ_MOD (repeated while team_id >= TEAMS, subtracting TEAMS),
// S_ENQ_WR, S_DONE; dequeue: accept, S_DEQ_TEAM, S_DEQ_CELL, S_DEQ_WR, S_DONE; full, empty:
// accept, S_DONE; clear: accept, S_SWEEP (activity sweep), S_DONE; one word at a time: the
// next word is taken once the previous result is loaded into the output register, and
// S_DONE waits while that register holds a word not yet taken; reset: asynchronous, active
// low; afterwards a sweep clears the team activity memory before the first word is taken
module grouped_team_fifo_unit
  import gtf_pkg::*;
#(
  parameter int unsigned TEAMS      = TEAMS_DEF,
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gtf_in_if.sink    in_i,
  gtf_out_if.source out_o
);

  gtf_cmd_t cmd;
  gtf_sts_t sts;

  // sequencer
  gtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // memories, pointers and result register
  gtf_dp #(
    .TEAMS      (TEAMS),
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .item_value_i (in_i.item_value),
    .team_id_i    (in_i.team_id),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_value_o  (out_o.out_value),
    .status_o     (out_o.status)
  );

endmodule
`default_nettype wire
